// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is low.
`define RBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("rba assertion failed");

// Next-cycle implication, muted while reset is low.
`define RBA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("rba assertion failed");

`endif

// ===== src/rba_pkg.sv =====
package rba_pkg;

	localparam int TEX_SLOTS_DEF = 16;
	localparam int VERT_MAX      = 65536;
	localparam int INDEX_MAX     = 65536;

	localparam logic [2:0] REQ_BEGIN = 3'd0;
	localparam logic [2:0] REQ_HDR   = 3'd1;
	localparam logic [2:0] REQ_PLACE = 3'd2;
	localparam logic [2:0] REQ_VTX   = 3'd3;
	localparam logic [2:0] REQ_IDX   = 3'd4;
	localparam logic [2:0] REQ_END   = 3'd5;

	localparam logic [2:0] RES_VTX  = 3'd0;
	localparam logic [2:0] RES_IDX  = 3'd1;
	localparam logic [2:0] RES_BIND = 3'd2;
	localparam logic [2:0] RES_DRAW = 3'd3;
	localparam logic [2:0] RES_DROP = 3'd4;

	localparam logic [1:0] CFG_MAX_SLOTS = 2'd0;
	localparam logic [1:0] CFG_VCAP      = 2'd1;
	localparam logic [1:0] CFG_ICAP      = 2'd2;

	// Control broadcast to every slot cell.
	typedef struct packed {
		logic        rotate;
		logic        load;
		logic [4:0]  used;
		logic [31:0] handle;
	} rba_cell_ctrl_t;

endpackage

// ===== src/rba_slot_cell.sv =====
module rba_slot_cell #(
	parameter int IDX = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rba_pkg::rba_cell_ctrl_t ctrl,
	input  logic [31:0]             shift_in,
	output logic [31:0]             handle_q,
	output logic                    match
);
	import rba_pkg::*;

	// Ring position only matters while the table is at rest (not rotating).
	assign match = (IDX >= 1) && (6'(IDX) < {1'b0, ctrl.used}) && (handle_q == ctrl.handle);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handle_q <= '0;
		end else if (ctrl.rotate) begin
			handle_q <= shift_in;
		end else if (ctrl.load && ({1'b0, ctrl.used} == 6'(IDX))) begin
			handle_q <= ctrl.handle;
		end
	end

endmodule

// ===== src/rba_xform.sv =====
module rba_xform (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] local_v,
	input  logic signed [31:0] scale,
	input  logic signed [31:0] pos,
	output logic signed [31:0] result
);
	import rba_pkg::*;

	logic signed [63:0] prod_s1;
	logic signed [47:0] q;
	logic signed [48:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= local_v * scale;
		end
	end

	// Arithmetic shift floors toward minus infinity.
	assign q   = 48'(prod_s1 >>> 16);
	assign sum = 49'(q) + 49'(pos);

	always_comb begin
		if (sum > 49'sd2147483647) begin
			result = 32'sh7FFFFFFF;
		end else if (sum < -49'sd2147483648) begin
			result = 32'sh80000000;
		end else begin
			result = sum[31:0];
		end
	end

endmodule

// ===== src/render_batch_assembler_top.sv =====
// Sprite batch assembler.
// Input channel in_valid/in_ready carries one request per transfer (begin scene,
// draw header, placement, vertex, index, end scene). Output channel
// out_valid/out_ready carries one result per transfer; last marks the final
// result of a request. cfg_valid/cfg_ready writes max_tex_slots (0),
// vertex_capacity (1), index_capacity (2); cfg_ready is always high.
// Index and drop results appear the cycle after the request; vertex
// results pass one multiply stage, then add and saturate into the output register.
// A flush (header or end scene) rotates the texture slot ring once through all
// TEX_SLOTS positions, emitting a bind per used slot, then one draw record; a
// header then does the slot search and allocation in the S_ALLOC state.
// Throughput: one request at a time; a vertex holds off the next request until
// its result is in the output register; indices every cycle while out_ready is
// high. A stalled receiver holds the output register and stops new requests.
// Reset clears the batch state and loads the register defaults; no sweep needed.
module render_batch_assembler_top #(
	parameter int TEX_SLOTS = rba_pkg::TEX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [31:0] tex_handle,
	input  logic [16:0] vert_count,
	input  logic [16:0] index_count,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic signed [31:0] aux_x,
	input  logic signed [31:0] aux_y,
	input  logic signed [31:0] aux_z,
	input  logic [15:0] local_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  res_type,
	output logic [15:0] addr,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_u,
	output logic signed [31:0] out_v,
	output logic [3:0]  slot,
	output logic [31:0] value,
	output logic [16:0] draw_index_count,
	output logic        last
);
	import rba_pkg::*;

	localparam int SW        = $clog2(TEX_SLOTS);
	localparam int SLOT_LIM  = (TEX_SLOTS < 16) ? TEX_SLOTS : 16;
	localparam int VCAP_LIM  = (VERT_MAX < 65536) ? VERT_MAX : 65536;
	localparam int ICAP_LIM  = (INDEX_MAX < 65536) ? INDEX_MAX : 65536;

	typedef enum logic [2:0] {S_IDLE, S_VTX, S_BIND, S_DRAW, S_ALLOC} state_t;

	state_t       state_q;
	logic [4:0]   max_slots_q;
	logic [16:0]  vcap_q, icap_q;
	logic [4:0]   slots_used_q;
	logic [16:0]  vfill_q, ifill_q, base_q;
	logic [3:0]   cur_slot_q;
	logic [31:0]  place_q [6];
	logic [31:0]  hdr_handle_q;
	logic         hdr_flush_q;
	logic [SW-1:0] step_q;
	logic [15:0]  vaddr_q;
	logic [31:0]  u_q, v_q;

	logic [4:0]   lim;
	logic [16:0]  vcap, icap;
	logic         out_free, in_xfer, flush_cond, bind_adv;
	logic         found;
	logic [3:0]   found_idx;
	logic [31:0]  ring [TEX_SLOTS];
	logic [TEX_SLOTS-1:0] match;
	rba_cell_ctrl_t ctrl;
	logic signed [31:0] tx, ty, tz;

	always_comb begin
		lim = max_slots_q;
		if (lim < 5'd2) lim = 5'd2;
		if (lim > 5'(SLOT_LIM)) lim = 5'(SLOT_LIM);
		vcap = vcap_q;
		if (vcap == 17'd0) vcap = 17'd1;
		if (vcap > 17'(VCAP_LIM)) vcap = 17'(VCAP_LIM);
		icap = icap_q;
		if (icap == 17'd0) icap = 17'd1;
		if (icap > 17'(ICAP_LIM)) icap = 17'(ICAP_LIM);
	end

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign in_xfer   = in_valid && in_ready;

	assign flush_cond = ({1'b0, vfill_q} + {1'b0, vert_count} > {1'b0, vcap})
		|| ({1'b0, ifill_q} + {1'b0, index_count} > {1'b0, icap})
		|| (slots_used_q >= lim);

	// Steps past the used slots emit nothing and need no free output.
	assign bind_adv = (state_q == S_BIND)
		&& (out_free || ({1'b0, 5'(step_q)} >= {1'b0, slots_used_q}));

	always_comb begin
		found     = 1'b0;
		found_idx = '0;
		for (int i = TEX_SLOTS - 1; i >= 1; i--) begin
			if (match[i]) begin
				found     = 1'b1;
				found_idx = 4'(i);
			end
		end
	end

	assign ctrl.rotate = bind_adv;
	assign ctrl.load   = (state_q == S_ALLOC) && (hdr_handle_q != '0) && !found
		&& ({1'b0, slots_used_q} < 6'(TEX_SLOTS));
	assign ctrl.used   = slots_used_q;
	assign ctrl.handle = hdr_handle_q;

	for (genvar g = 0; g < TEX_SLOTS; g++) begin : g_cell
		rba_slot_cell #(.IDX(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.shift_in (ring[(g + 1) % TEX_SLOTS]),
			.handle_q (ring[g]),
			.match    (match[g])
		);
	end

	logic vtx_go;
	assign vtx_go = in_xfer && (req_type == REQ_VTX) && (vfill_q < vcap);

	rba_xform u_tx (.clk(clk), .en(vtx_go), .local_v(coord_x), .scale(place_q[3]),
		.pos(place_q[0]), .result(tx));
	rba_xform u_ty (.clk(clk), .en(vtx_go), .local_v(coord_y), .scale(place_q[4]),
		.pos(place_q[1]), .result(ty));
	rba_xform u_tz (.clk(clk), .en(vtx_go), .local_v(coord_z), .scale(place_q[5]),
		.pos(place_q[2]), .result(tz));

	always_ff @(posedge clk) begin
		if (vtx_go) begin
			vaddr_q <= vfill_q[15:0];
			u_q     <= aux_x;
			v_q     <= aux_y;
		end
		if (in_xfer && req_type == REQ_HDR) begin
			hdr_handle_q <= tex_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_slots_q  <= 5'd16;
			vcap_q       <= 17'd65536;
			icap_q       <= 17'd65536;
			slots_used_q <= 5'd1;
			vfill_q      <= '0;
			ifill_q      <= '0;
			base_q       <= '0;
			cur_slot_q   <= '0;
			for (int i = 0; i < 6; i++) place_q[i] <= '0;
			hdr_flush_q  <= 1'b0;
			step_q       <= '0;
			out_valid    <= 1'b0;
			res_type     <= '0;
			addr         <= '0;
			out_x        <= '0;
			out_y        <= '0;
			out_z        <= '0;
			out_u        <= '0;
			out_v        <= '0;
			slot         <= '0;
			value        <= '0;
			draw_index_count <= '0;
			last         <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MAX_SLOTS: max_slots_q <= cfg_data[4:0];
					CFG_VCAP:      vcap_q      <= cfg_data;
					CFG_ICAP:      icap_q      <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid && out_ready) out_valid <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (req_type)
							REQ_BEGIN: begin
								vfill_q      <= '0;
								ifill_q      <= '0;
								base_q       <= '0;
								cur_slot_q   <= '0;
								slots_used_q <= 5'd1;
							end
							REQ_HDR: begin
								step_q      <= '0;
								hdr_flush_q <= flush_cond;
								state_q     <= flush_cond ? S_BIND : S_ALLOC;
							end
							REQ_PLACE: begin
								place_q[0] <= coord_x;
								place_q[1] <= coord_y;
								place_q[2] <= coord_z;
								place_q[3] <= aux_x;
								place_q[4] <= aux_y;
								place_q[5] <= aux_z;
							end
							REQ_VTX, REQ_IDX: begin
								out_valid <= 1'b1;
								addr      <= '0;
								out_x     <= '0;
								out_y     <= '0;
								out_z     <= '0;
								out_u     <= '0;
								out_v     <= '0;
								slot      <= '0;
								value     <= '0;
								draw_index_count <= '0;
								last      <= 1'b1;
								res_type  <= RES_DROP;
								if (req_type == REQ_VTX) begin
									if (vfill_q < vcap) begin
										out_valid <= 1'b0;
										vfill_q   <= vfill_q + 17'd1;
										state_q   <= S_VTX;
									end
								end else if (ifill_q < icap) begin
									res_type <= RES_IDX;
									addr     <= ifill_q[15:0];
									value    <= 32'({1'b0, local_index} + base_q);
									ifill_q  <= ifill_q + 17'd1;
								end
							end
							REQ_END: begin
								step_q      <= '0;
								hdr_flush_q <= 1'b0;
								state_q     <= S_BIND;
							end
							default: ;
						endcase
					end
				end
				S_VTX: begin
					if (out_free) begin
						out_valid <= 1'b1;
						res_type  <= RES_VTX;
						addr      <= vaddr_q;
						out_x     <= tx;
						out_y     <= ty;
						out_z     <= tz;
						out_u     <= u_q;
						out_v     <= v_q;
						slot      <= cur_slot_q;
						value     <= '0;
						draw_index_count <= '0;
						last      <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_BIND: begin
					if (bind_adv) begin
						if ({1'b0, 5'(step_q)} < {1'b0, slots_used_q}) begin
							out_valid <= 1'b1;
							res_type  <= RES_BIND;
							addr      <= '0;
							out_x     <= '0;
							out_y     <= '0;
							out_z     <= '0;
							out_u     <= '0;
							out_v     <= '0;
							slot      <= 4'(step_q);
							value     <= ring[0];
							draw_index_count <= '0;
							last      <= 1'b0;
						end
						step_q <= step_q + 1'b1;
						if (step_q == SW'(TEX_SLOTS - 1)) state_q <= S_DRAW;
					end
				end
				S_DRAW: begin
					if (out_free) begin
						out_valid <= 1'b1;
						res_type  <= RES_DRAW;
						addr      <= '0;
						out_x     <= '0;
						out_y     <= '0;
						out_z     <= '0;
						out_u     <= '0;
						out_v     <= '0;
						slot      <= '0;
						value     <= 32'(vfill_q);
						draw_index_count <= ifill_q;
						last      <= 1'b1;
						if (hdr_flush_q) begin
							vfill_q      <= '0;
							ifill_q      <= '0;
							slots_used_q <= 5'd1;
							state_q      <= S_ALLOC;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ALLOC: begin
					cur_slot_q <= '0;
					if (hdr_handle_q != '0) begin
						if (found) begin
							cur_slot_q <= found_idx;
						end else if (ctrl.load) begin
							cur_slot_q   <= slots_used_q[3:0];
							slots_used_q <= slots_used_q + 5'd1;
						end
					end
					base_q  <= vfill_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/rba_checker.sv =====
`include "assert_macros.svh"

module rba_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  res_type,
	input logic [31:0] value,
	input logic        last
);
	import rba_pkg::*;

	`RBA_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(value))
	`RBA_ASSERT_IMP(a_ready_free, clk, arst_n, in_ready, !out_valid || out_ready)
	`RBA_ASSERT_IMP(a_bind_not_last, clk, arst_n, out_valid && res_type == RES_BIND, !last)
	`RBA_ASSERT_IMP(a_single_last, clk, arst_n, out_valid && (res_type == RES_VTX || res_type == RES_IDX || res_type == RES_DROP || res_type == RES_DRAW), last)

endmodule

bind render_batch_assembler_top rba_checker u_rba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.res_type  (res_type),
	.value     (value),
	.last      (last)
);

// ===== tb/sv/render_batch_assembler_top_tb.sv =====
`default_nettype none

module render_batch_assembler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rba_pkg::*;

	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam int SLOT_HW = 16;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] handle;
		logic [16:0] vcnt;
		logic [16:0] icnt;
		logic [31:0] cx, cy, cz, ax, ay, az;
		logic [15:0] lidx;
	} req_t;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] addr;
		logic [31:0] x, y, z, u, v;
		logic [3:0]  slot;
		logic [31:0] value;
		logic [16:0] dic;
		logic        last;
	} res_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [16:0] cfg_data;
	logic in_valid, in_ready;
	logic [2:0] req_type;
	logic [31:0] tex_handle;
	logic [16:0] vert_count, index_count;
	logic signed [31:0] coord_x, coord_y, coord_z, aux_x, aux_y, aux_z;
	logic [15:0] local_index;
	logic out_valid, out_ready;
	logic [2:0] res_type;
	logic [15:0] addr;
	logic signed [31:0] out_x, out_y, out_z, out_u, out_v;
	logic [3:0] slot;
	logic [31:0] value;
	logic [16:0] draw_index_count;
	logic last;

	render_batch_assembler_top u_top (.*);

	// shadow of the block's batch state and registers
	logic [4:0]  reg_slots;
	logic [16:0] reg_vcap, reg_icap;
	logic [31:0] slot_handle_sh[SLOT_HW];
	logic [31:0] place_sh[6];
	int unsigned used_sh, vfill_sh, ifill_sh, base_sh, cur_sh;

	res_t expected_results[$];
	int errors = 0;
	bit calm = 1'b0;
	int hold_cycles = 0;

	initial forever #10 clk = ~clk;

	initial begin
		#50ms;
		$display("render_batch_assembler_top_tb: errors");
		$finish;
	end

	// receiver: random stalls, or a long hold-off when requested
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result type %0d", res_type);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (res_type !== e.kind) begin $error("res_type exp %0d got %0d", e.kind, res_type); errors++; end
				if (addr !== e.addr) begin $error("addr exp %0d got %0d", e.addr, addr); errors++; end
				if (out_x !== e.x) begin $error("out_x exp %h got %h", e.x, out_x); errors++; end
				if (out_y !== e.y) begin $error("out_y exp %h got %h", e.y, out_y); errors++; end
				if (out_z !== e.z) begin $error("out_z exp %h got %h", e.z, out_z); errors++; end
				if (out_u !== e.u) begin $error("out_u exp %h got %h", e.u, out_u); errors++; end
				if (out_v !== e.v) begin $error("out_v exp %h got %h", e.v, out_v); errors++; end
				if (slot !== e.slot) begin $error("slot exp %0d got %0d", e.slot, slot); errors++; end
				if (value !== e.value) begin $error("value exp %h got %h", e.value, value); errors++; end
				if (draw_index_count !== e.dic) begin
					$error("draw_index_count exp %0d got %0d", e.dic, draw_index_count);
					errors++;
				end
				if (last !== e.last) begin $error("last exp %0d got %0d", e.last, last); errors++; end
			end
		end
	end

	function automatic logic [31:0] scale_offset(logic [31:0] loc, logic [31:0] scl,
			logic [31:0] pos);
		longint p, s;
		p = longint'($signed(loc)) * longint'($signed(scl));
		s = (p >>> 16) + longint'($signed(pos));
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic void push_result(logic [2:0] k, logic [15:0] a, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] u, logic [31:0] v,
			logic [3:0] s, logic [31:0] val, logic [16:0] dic);
		res_t r;
		r = '{k, a, x, y, z, u, v, s, val, dic, 1'b0};
		expected_results.push_back(r);
	endfunction

	function automatic void emit_batch();
		for (int i = 0; i < used_sh && i < SLOT_HW; i++)
			push_result(RES_BIND, 0, 0, 0, 0, 0, 0, i, slot_handle_sh[i], 0);
		push_result(RES_DRAW, 0, 0, 0, 0, 0, 0, 0, vfill_sh, ifill_sh);
	endfunction

	function automatic void predict_batch(req_t r);
		int unsigned vcap, icap, lim, n0;
		bit found;
		n0 = expected_results.size();
		vcap = (reg_vcap < 1) ? 1 : (reg_vcap > 65536) ? 65536 : reg_vcap;
		icap = (reg_icap < 1) ? 1 : (reg_icap > 65536) ? 65536 : reg_icap;
		lim = (reg_slots < 2) ? 2 : (reg_slots > SLOT_HW) ? SLOT_HW : reg_slots;
		case (r.kind)
			REQ_BEGIN: begin
				vfill_sh = 0; ifill_sh = 0; used_sh = 1; base_sh = 0; cur_sh = 0;
			end
			REQ_HDR: begin
				if (vfill_sh + r.vcnt > vcap || ifill_sh + r.icnt > icap || used_sh >= lim) begin
					emit_batch();
					vfill_sh = 0; ifill_sh = 0; used_sh = 1;
				end
				cur_sh = 0;
				if (r.handle != 0) begin
					found = 1'b0;
					for (int i = 1; i < used_sh && !found; i++)
						if (slot_handle_sh[i] == r.handle) begin
							cur_sh = i;
							found = 1'b1;
						end
					if (!found && used_sh < SLOT_HW) begin
						cur_sh = used_sh;
						slot_handle_sh[used_sh] = r.handle;
						used_sh++;
					end
				end
				base_sh = vfill_sh;
			end
			REQ_PLACE: begin
				place_sh = '{r.cx, r.cy, r.cz, r.ax, r.ay, r.az};
			end
			REQ_VTX: begin
				if (vfill_sh < vcap) begin
					push_result(RES_VTX, vfill_sh[15:0],
						scale_offset(r.cx, place_sh[3], place_sh[0]),
						scale_offset(r.cy, place_sh[4], place_sh[1]),
						scale_offset(r.cz, place_sh[5], place_sh[2]),
						r.ax, r.ay, cur_sh[3:0], 0, 0);
					vfill_sh++;
				end else begin
					push_result(RES_DROP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
				end
			end
			REQ_IDX: begin
				if (ifill_sh < icap) begin
					push_result(RES_IDX, ifill_sh[15:0], 0, 0, 0, 0, 0, 0,
						32'(r.lidx) + base_sh, 0);
					ifill_sh++;
				end else begin
					push_result(RES_DROP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
				end
			end
			REQ_END: emit_batch();
			default: ;
		endcase
		if (expected_results.size() > n0)
			expected_results[$].last = 1'b1;
	endfunction

	task automatic send_req(req_t r);
		if (!calm && $urandom_range(0, 99) < 22) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		tex_handle <= r.handle;
		vert_count <= r.vcnt;
		index_count <= r.icnt;
		coord_x <= r.cx; coord_y <= r.cy; coord_z <= r.cz;
		aux_x <= r.ax; aux_y <= r.ay; aux_z <= r.az;
		local_index <= r.lidx;
		do @(posedge clk); while (!in_ready);
		predict_batch(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(logic [1:0] idx, logic [16:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MAX_SLOTS: reg_slots = data[4:0];
			CFG_VCAP: reg_vcap = data;
			CFG_ICAP: reg_icap = data;
			default: ;
		endcase
	endtask

	task automatic set_limits(logic [16:0] slots, logic [16:0] vcap, logic [16:0] icap);
		write_reg(CFG_MAX_SLOTS, slots);
		write_reg(CFG_VCAP, vcap);
		write_reg(CFG_ICAP, icap);
		cfg_valid <= 1'b0;
	endtask

	function automatic req_t mk(logic [2:0] k);
		req_t r;
		r = '{k, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
		return r;
	endfunction

	function automatic logic [31:0] q16();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
	endfunction

	task automatic send_hdr(logic [31:0] h, logic [16:0] vc, logic [16:0] ic);
		req_t r;
		r = mk(REQ_HDR);
		r.handle = h; r.vcnt = vc; r.icnt = ic;
		send_req(r);
	endtask

	task automatic send_place(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [31:0] sx, logic [31:0] sy, logic [31:0] sz);
		req_t r;
		r = mk(REQ_PLACE);
		r.cx = px; r.cy = py; r.cz = pz; r.ax = sx; r.ay = sy; r.az = sz;
		send_req(r);
	endtask

	task automatic send_vtx(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [31:0] u, logic [31:0] v);
		req_t r;
		r = mk(REQ_VTX);
		r.cx = x; r.cy = y; r.cz = z; r.ax = u; r.ay = v; r.az = $urandom;
		send_req(r);
	endtask

	task automatic send_idx(logic [15:0] li);
		req_t r;
		r = mk(REQ_IDX);
		r.lidx = li;
		send_req(r);
	endtask

	task automatic test_directed();
		calm = 1'b1;
		send_req(mk(REQ_BEGIN));
		send_hdr(0, 17'd65536, 17'd65536);
		send_place(32'h7fffffff, 32'h80000000, 0, 32'h00010000, 32'h7fffffff, 32'h80000000);
		send_vtx(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000, 32'h7fffffff);
		send_vtx(32'h00010000, 32'h00010000, 32'h80000000, 0, 32'hffffffff);
		send_hdr(32'hffffffff, 0, 0);
		send_idx(16'hffff);
		send_idx(0);
		send_hdr(32'hffffffff, 1, 1);
		send_req(mk(REQ_SPARE_A));
		send_req(mk(REQ_SPARE_B));
		send_req(mk(REQ_END));
		send_hdr(32'h12345678, 17'd65536, 0);  // counts overflow: flush then allocate
		send_req(mk(REQ_END));
		drain();
		calm = 1'b0;
	endtask

	// small capacities: overflow flushes, full slot table, dropped writes
	task automatic test_capacity();
		set_limits(17'd0, 17'd2, 17'd1);
		send_req(mk(REQ_BEGIN));
		send_hdr(7, 2, 1);
		repeat (3) send_vtx(q16(), q16(), q16(), $urandom, $urandom);
		repeat (2) send_idx($urandom);
		send_hdr(9, 1, 1);
		send_hdr(7, 0, 0);
		send_req(mk(REQ_END));
		drain();
		set_limits(17'd31, 17'h1ffff, 17'd0);
		send_req(mk(REQ_BEGIN));
		for (int i = 1; i <= 17; i++) send_hdr(i, 0, 0);
		send_hdr(3, 0, 0);
		send_idx(5);
		send_idx(6);
		send_req(mk(REQ_END));
		drain();
	endtask

	task automatic random_scene(int n_draws);
		int nv, ni;
		logic [31:0] h;
		send_req(mk(REQ_BEGIN));
		for (int d = 0; d < n_draws; d++) begin
			case ($urandom_range(0, 9))
				0: h = 0;
				1: h = $urandom;
				default: h = $urandom_range(1, 12);
			endcase
			nv = $urandom_range(0, 6);
			ni = $urandom_range(0, 8);
			if ($urandom_range(0, 9) == 0) send_hdr(h, $urandom_range(0, 17'h1ffff), $urandom);
			else send_hdr(h, nv, ni);
			if ($urandom_range(0, 4) != 0) send_place(q16(), q16(), q16(), q16(), q16(), q16());
			for (int i = 0; i < nv; i++) send_vtx(q16(), q16(), q16(), $urandom, $urandom);
			for (int i = 0; i < ni; i++) send_idx($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom);
			if ($urandom_range(0, 14) == 0) send_req(mk(3'($urandom_range(0, 7))));
		end
		send_req(mk(REQ_END));
	endtask

	task automatic test_random_scenes();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: set_limits(17'd16, 17'd65536, 17'd65536);
				1: set_limits(17'd3, 17'd12, 17'd16);
				2: set_limits(17'd2, 17'd5, 17'd3);
				default: set_limits(17'd6, 17'd30, 17'd40);
			endcase
			calm = (ph == 1);
			for (int s = 0; s < 3; s++) random_scene($urandom_range(1, 4));
			drain();
		end
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		set_limits(17'd4, 17'd65536, 17'd65536);
		send_req(mk(REQ_BEGIN));
		send_hdr(1, 40, 40);
		hold_cycles = 400;
		repeat (20) send_vtx(q16(), q16(), q16(), $urandom, $urandom);
		repeat (20) send_idx($urandom);
		send_req(mk(REQ_END));
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
		in_valid <= 1'b0; req_type <= '0; tex_handle <= '0;
		vert_count <= '0; index_count <= '0;
		coord_x <= '0; coord_y <= '0; coord_z <= '0;
		aux_x <= '0; aux_y <= '0; aux_z <= '0; local_index <= '0;
		reg_slots = 5'd16; reg_vcap = 17'd65536; reg_icap = 17'd65536;
		foreach (slot_handle_sh[i]) slot_handle_sh[i] = '0;
		foreach (place_sh[i]) place_sh[i] = '0;
		used_sh = 1; vfill_sh = 0; ifill_sh = 0; base_sh = 0; cur_sh = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_capacity();
		test_random_scenes();
		test_backpressure();
		drain();
		if (errors == 0)
			$display("render_batch_assembler_top_tb: clean");
		else
			$display("render_batch_assembler_top_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
